/* design/hesm_pkg.sv */
// shared types, constants and command codes of the shade map unit
`default_nettype none
package hesm_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int TABLE_DEPTH = 256;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = 64;
  localparam logic [7:0] SHADE_TOP = 8'd255;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_MAP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // request to the sequential divider and its answer
  typedef struct packed {
    logic          start;
    logic [SW-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [SW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* design/histogram_equalized_shade_map_unit.sv */
// shade map unit: count store, in-place heap sort, breakpoint build and map search
//
// One request at a time. A load or clear goes through the output state to its result;
// a map query runs a binary search over the breakpoint table of up to 9 halving steps,
// each of which sets the table address, waits for the registered read and compares.
// A build runs the count sum (one store read a cycle), a divide by 255 that folds
// base-256 digits, an in-place heap sort of the N counts through the store's one read
// and one write port, and a final walk. s_tuser: [1:0] command. s_tdata: [31:0]
// hit_value. m_tdata: [7:0] shade, [16:8] breakpoint_total, [17] overflow,
// [23:18] zero.
`default_nettype none
module histogram_equalized_shade_map_unit
  import hesm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // hit_value
  input  wire logic [1:0]  s_tuser,  // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata   // shade, breakpoint_total, overflow
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SUM   = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_HEAP  = 4'd3;
  localparam logic [3:0] ST_SRD   = 4'd4;
  localparam logic [3:0] ST_SCMP  = 4'd5;
  localparam logic [3:0] ST_SWR   = 4'd6;
  localparam logic [3:0] ST_WALK  = 4'd7;
  localparam logic [3:0] ST_MAP   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;
  localparam logic [3:0] ST_RD0   = 4'd10;
  localparam logic [3:0] ST_RDC   = 4'd11;
  localparam logic [3:0] ST_WAIT  = 4'd12;

  logic [3:0] state;

  // memories
  logic [31:0] store [MAX_POINTS];
  logic [31:0] bptab [TABLE_DEPTH];
  logic [31:0] st_rd;
  logic [31:0] bp_rd;
  logic [AW-1:0] st_addr;
  logic [TW-1:0] bp_addr;

  logic [CW-1:0] loaded;
  logic [UW-1:0] used;
  logic [31:0]   val;
  logic [7:0]    shade;
  logic          ovf;

  logic [SW-1:0] acc;
  logic [SW-1:0] interval;
  logic [CW-1:0] idx;
  logic [CW-1:0] heap_n;
  logic [CW-1:0] heap_i;
  logic          phase2;
  logic [CW:0]   root;
  logic [CW:0]   child;
  logic [31:0]   root_v;
  logic [31:0]   child_v;
  logic [31:0]   tmp_v;
  logic [2:0]    sub;
  logic [UW-1:0] lo;
  logic [UW-1:0] hi;

  logic          st_we;
  logic [AW-1:0] st_wa;
  logic [31:0]   st_wd;

  div_req_t dreq;
  div_rsp_t drsp;

  hesm_div255 u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  // store and table ports, read data registered
  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    st_rd <= store[st_addr];
    bp_rd <= bptab[bp_addr];
  end

  always_ff @(posedge clk) begin
    dreq.start    <= 1'b0;
    st_we         <= 1'b0;
    if (rst) begin
      state    <= ST_IDLE;
      loaded   <= '0;
      used     <= '0;
      m_tvalid <= 1'b0;
      dreq.dividend <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            val   <= s_tdata;
            shade <= '0;
            ovf   <= 1'b0;
            case (s_tuser)
              CMD_LOAD: begin
                if (loaded < CW'(MAX_POINTS)) begin
                  st_we  <= 1'b1;
                  st_wa  <= loaded[AW-1:0];
                  st_wd  <= s_tdata;
                  loaded <= loaded + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
                state <= ST_OUT;
              end
              CMD_BUILD: begin
                acc     <= '0;
                idx     <= '0;
                st_addr <= '0;
                used    <= '0;
                state   <= ST_SUM;
              end
              CMD_MAP: begin
                lo      <= '0;
                hi      <= used;
                sub     <= '0;
                state   <= ST_MAP;
              end
              default: begin
                loaded <= '0;
                state  <= ST_OUT;
              end
            endcase
          end
        end
        // sum all counts, one read a cycle (read data is registered, so it lags the address)
        ST_SUM: begin
          if (idx != '0) acc <= acc + SW'(st_rd);
          if (idx == loaded) begin
            state <= ST_DIV;
            dreq.start    <= 1'b1;
            dreq.dividend <= (idx == '0) ? '0 : acc + SW'(st_rd);
          end else begin
            idx     <= idx + 1'b1;
            st_addr <= AW'(idx + 1'b1);
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            interval <= drsp.quotient;
            phase2   <= 1'b0;
            heap_n   <= loaded;
            heap_i   <= loaded >> 1;
            state    <= (loaded < CW'(2)) ? ST_WAIT : ST_HEAP;
          end
        end
        // heap sort driver: pick next sift root
        ST_HEAP: begin
          if (!phase2) begin
            if (heap_i == '0) begin
              phase2 <= 1'b1;
              heap_i <= heap_n - 1'b1;
            end else begin
              root   <= (CW+1)'(heap_i - 1'b1);
              heap_i <= heap_i - 1'b1;
              state  <= ST_SRD;
              sub    <= '0;
            end
          end else begin
            if (heap_i == '0) begin
              state <= ST_WAIT;
            end else begin
              // swap a[0] and a[i]: read both then write
              case (sub)
                3'd0: begin st_addr <= '0; sub <= 3'd1; end
                3'd1: begin st_addr <= heap_i[AW-1:0]; sub <= 3'd2; end
                3'd2: begin tmp_v <= st_rd; sub <= 3'd3; end
                3'd3: begin
                  st_we <= 1'b1; st_wa <= '0; st_wd <= st_rd; sub <= 3'd4;
                end
                default: begin
                  st_we  <= 1'b1; st_wa <= heap_i[AW-1:0]; st_wd <= tmp_v;
                  heap_n <= heap_i;
                  heap_i <= heap_i - 1'b1;
                  root   <= '0;
                  sub    <= '0;
                  state  <= ST_SRD;
                end
              endcase
            end
          end
        end
        // sift down: read root and children
        ST_SRD: begin
          child <= (root << 1) + 1'b1;
          case (sub)
            3'd0: begin st_addr <= root[AW-1:0]; sub <= 3'd1; end
            3'd1: begin
              if (((root << 1) + 1'b1) >= (CW+1)'(heap_n)) begin
                state <= ST_HEAP; sub <= '0;
              end else begin
                st_addr <= AW'((root << 1) + 1'b1); sub <= 3'd2;
              end
            end
            3'd2: begin
              root_v <= st_rd;
              if (((root << 1) + 2'd2) < (CW+1)'(heap_n)) begin
                st_addr <= AW'((root << 1) + 2'd2); sub <= 3'd3;
              end else begin
                sub <= 3'd5;
              end
            end
            3'd3: begin child_v <= st_rd; sub <= 3'd4; end
            3'd4: begin
              if (st_rd > child_v) begin
                child_v <= st_rd; child <= (root << 1) + 2'd2;
              end
              state <= ST_SCMP;
            end
            default: begin child_v <= st_rd; state <= ST_SCMP; end
          endcase
        end
        ST_SCMP: begin
          sub <= '0;
          if (root_v >= child_v) begin
            state <= ST_HEAP;
          end else begin
            st_we <= 1'b1; st_wa <= root[AW-1:0]; st_wd <= child_v;
            state <= ST_SWR;
          end
        end
        ST_SWR: begin
          st_we <= 1'b1; st_wa <= child[AW-1:0]; st_wd <= root_v;
          root  <= child;
          sub   <= '0;
          state <= ST_SRD;
        end
        // walk sorted counts and record breakpoints
        ST_WAIT: begin
          idx <= '0; st_addr <= '0; acc <= '0; state <= ST_WALK;
        end
        ST_WALK: begin
          if (idx != '0) begin
            if (acc + SW'(st_rd) > interval) begin
              acc <= '0;
              if (used < UW'(TABLE_DEPTH)) begin
                bptab[used[TW-1:0]] <= st_rd;
                used <= used + 1'b1;
              end
            end else begin
              acc <= acc + SW'(st_rd);
            end
          end
          if (idx == loaded) state <= ST_OUT;
          else begin
            idx <= idx + 1'b1; st_addr <= AW'(idx + 1'b1);
          end
        end
        // binary search: count of entries strictly below value
        ST_MAP: begin
          case (sub)
            3'd0: begin
              if (lo == hi) begin
                shade <= (lo >= UW'(SHADE_TOP)) ? 8'd0 : SHADE_TOP - lo[7:0];
                state <= ST_OUT;
              end else begin
                bp_addr <= TW'((lo + hi) >> 1); sub <= 3'd1;
              end
            end
            3'd1: sub <= 3'd2;
            default: begin
              if (bp_rd < val) lo <= UW'(bp_addr) + 1'b1;
              else hi <= UW'(bp_addr);
              sub <= 3'd0;
            end
          endcase
        end
        ST_OUT: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {6'd0, ovf, used, shade};
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result only ever leaves with an idle sequencer
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == ST_IDLE)) else $error("result while busy");
  // loads never exceed capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(MAX_POINTS)) else $error("store overrun");
  a_used: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(TABLE_DEPTH)) else $error("table overrun");
  // divider busy only while the sequencer waits on it in ST_DIV
  a_div: assert property (@(posedge clk) disable iff (rst)
    drsp.busy |-> (state == ST_DIV)) else $error("divider out of step");

endmodule
`default_nettype wire

/* design/hesm_div255.sv */
// divide by 255 by folding base-256 digits, x = 256a + b gives x/255 = a + (a + b)/255
`default_nettype none
module hesm_div255
  import hesm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [SW-1:0] quo;
  logic [SW-1:0] rest;
  logic          busy;
  logic          done;
  logic [SW-1:0] upper;
  logic [SW-1:0] fold;

  assign upper = rest >> 8;
  assign fold  = upper + SW'(rest[7:0]);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      quo  <= '0;
      rest <= req.dividend;
    end else if (busy) begin
      if (rest[SW-1:8] != '0) begin
        // move the upper digits into the quotient and fold them back in
        quo  <= quo + upper;
        rest <= fold;
      end else begin
        // remainder below 256: one more unit when it equals 255
        if (rest[7:0] == 8'd255) quo <= quo + SW'(1);
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire
